>>> src/swc_pkg.sv
// Shared types and constants for the sync word correlator.
`timescale 1ns / 1ps
package swc_pkg;

    localparam int DATA_W  = 8;
    localparam int DIST_W  = 7;
    localparam int CFG_W   = 64;
    localparam int CODE_MAX = 64;
    localparam int GRP_W   = 8;
    localparam int GRP_N   = CODE_MAX / GRP_W;
    localparam int GRP_CNT_W = 4;

    localparam logic [CFG_W-1:0] MAIN_RESET = 64'hACDD_A4E2_F28C_20FC;
    localparam logic [CFG_W-1:0] ROT_RESET  = 64'hF644_F27B_5BE6_BA56;

    typedef enum logic [0:0] {
        REG_MAIN_CODE = 1'b0,
        REG_ROT_CODE  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              found;
        logic              rot;
        logic [DIST_W-1:0] distance;
    } t_match;

endpackage

>>> src/swc_hist.sv
// Bit history shift register and saturating fill count.
`timescale 1ns / 1ps
module swc_hist #(
    parameter int CODE_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_bit,
    output logic [CODE_BITS-1:0] o_hist,
    output logic                 o_full
);
    localparam int CNT_W = $clog2(CODE_BITS + 1);

    logic [CODE_BITS-1:0] r_hist;
    logic [CODE_BITS-1:0] n_hist;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 full;

    assign full = (r_cnt == CNT_W'(CODE_BITS));

    always_comb begin
        n_hist = r_hist;
        n_cnt  = r_cnt;
        if (i_shift) begin
            n_hist = {r_hist[CODE_BITS-2:0], i_bit};
            if (!full) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_cnt  <= '0;
        end else begin
            r_hist <= n_hist;
            r_cnt  <= n_cnt;
        end
    end

    assign o_hist = r_hist;
    assign o_full = full;

endmodule

>>> src/swc_match.sv
// Distance check of the history against the main and rotated codes.
`timescale 1ns / 1ps
module swc_match #(
    parameter int CODE_BITS = 64
) (
    input  logic [CODE_BITS-1:0] i_hist,
    input  logic [CODE_BITS-1:0] i_main_code,
    input  logic [CODE_BITS-1:0] i_rot_code,
    output swc_pkg::t_match      o_res
);
    import swc_pkg::*;

    localparam logic [DIST_W-1:0] HALF_DIST = DIST_W'(CODE_BITS / 2);
    localparam logic [DIST_W-1:0] FULL_DIST = DIST_W'(CODE_BITS);

    logic [CODE_BITS-1:0] x_main;
    logic [CODE_BITS-1:0] x_rot;
    logic [CODE_MAX-1:0]  x_pad;
    logic [GRP_CNT_W-1:0] grp_cnt [GRP_N];
    logic [DIST_W-1:0]    pop;
    logic                 half;
    logic                 main_zero;
    logic                 main_ones;
    logic                 rot_zero;
    logic                 rot_ones;

    assign x_main = i_hist ^ i_main_code;
    assign x_rot  = i_hist ^ i_rot_code;
    assign x_pad  = CODE_MAX'(x_main);

    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            grp_cnt[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                grp_cnt[g] = grp_cnt[g] + GRP_CNT_W'(x_pad[g*GRP_W + b]);
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int g = 0; g < GRP_N; g++) begin
            pop = pop + DIST_W'(grp_cnt[g]);
        end
    end

    assign half      = (pop == HALF_DIST);
    assign main_zero = (x_main == '0);
    assign main_ones = (x_main == '1);
    assign rot_zero  = (x_rot == '0);
    assign rot_ones  = (x_rot == '1);

    always_comb begin
        o_res.rot = half;
        if (half) begin
            o_res.found    = rot_zero | rot_ones;
            o_res.distance = rot_ones ? FULL_DIST : '0;
        end else begin
            o_res.found    = main_zero | main_ones;
            o_res.distance = main_ones ? FULL_DIST : '0;
        end
    end

endmodule

>>> src/sync_word_correlator_phase_resolve_top.sv
// Top level of the sliding sync word correlator with phase resolution.
//
// Input channel: i_valid / o_stall carry one byte per word; bit 0 is the
// received hard bit. Output channel: o_valid / i_stall carry the byte back
// unchanged with tag_found, tag_distance and rotated_hit.
// Every input word yields exactly one output word; the result register
// takes it from the input stage unless the output is stalled. One word is
// taken per cycle while o_stall is low; the rate is set by the two-stage
// register pipeline (input stage, then correlation into the result register).
// The first CODE_BITS words fill the history and never raise a tag.
// The user writes codes via i_cfg_we / i_cfg_idx / i_cfg_data only while
// the block is idle (not enforced); only the low CODE_BITS bits are used.
// Reset (synchronous, active low) empties the pipeline, clears the
// history and fill count and loads the default codes.
// When the receiver stalls, the result holds; an empty input stage still
// takes one more word, then o_stall rises until the result register drains.
`timescale 1ns / 1ps
module sync_word_correlator_phase_resolve_top #(
    parameter int CODE_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [swc_pkg::DATA_W-1:0]  i_data_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [swc_pkg::DATA_W-1:0]  o_data_out,
    output logic                        o_tag_found,
    output logic [swc_pkg::DIST_W-1:0]  o_tag_distance,
    output logic                        o_rotated_hit,
    input  logic                        i_cfg_we,
    input  swc_pkg::t_reg_idx           i_cfg_idx,
    input  logic [swc_pkg::CFG_W-1:0]   i_cfg_data
);
    import swc_pkg::*;

    logic [CODE_BITS-1:0] r_main_code;
    logic [CODE_BITS-1:0] r_rot_code;

    logic                 r_s1_valid;
    logic                 n_s1_valid;
    logic [DATA_W-1:0]    r_s1_data;
    logic [CODE_BITS-1:0] r_s1_hist;
    logic                 r_s1_cmp;

    logic                 r_o_valid;
    logic [DATA_W-1:0]    r_o_data;
    logic                 r_o_found;
    logic [DIST_W-1:0]    r_o_dist;
    logic                 r_o_rot;

    logic                 s1_adv;
    logic                 in_acc;
    logic [CODE_BITS-1:0] hist;
    logic                 full;
    t_match               res;
    logic                 tag;

    assign s1_adv  = !r_o_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;
    assign n_s1_valid = in_acc || (r_s1_valid && !s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_code <= MAIN_RESET[CODE_BITS-1:0];
            r_rot_code  <= ROT_RESET[CODE_BITS-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAIN_CODE: r_main_code <= i_cfg_data[CODE_BITS-1:0];
                REG_ROT_CODE:  r_rot_code  <= i_cfg_data[CODE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    swc_hist #(
        .CODE_BITS(CODE_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_acc),
        .i_bit   (i_data_in[0]),
        .o_hist  (hist),
        .o_full  (full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_data <= i_data_in;
            r_s1_hist <= hist;
            r_s1_cmp  <= full;
        end
    end

    swc_match #(
        .CODE_BITS(CODE_BITS)
    ) u_match (
        .i_hist      (r_s1_hist),
        .i_main_code (r_main_code),
        .i_rot_code  (r_rot_code),
        .o_res       (res)
    );

    assign tag = r_s1_cmp && res.found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_o_data  <= r_s1_data;
            r_o_found <= tag;
            r_o_dist  <= tag ? res.distance : '0;
            r_o_rot   <= tag && res.rot;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_data_out     = r_o_data;
    assign o_tag_found    = r_o_found;
    assign o_tag_distance = r_o_dist;
    assign o_rotated_hit  = r_o_rot;

    a_tag_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tag_found) |->
            (o_tag_distance == '0 || o_tag_distance == DIST_W'(CODE_BITS)))
        else $error("tag with distance other than match or inverted match");

    a_no_tag_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tag_found) |-> (o_tag_distance == '0 && !o_rotated_hit))
        else $error("untagged word carries distance or rotated flag");

    a_fill_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && !r_s1_cmp) |=> (o_valid && !o_tag_found))
        else $error("tag raised while history is filling");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_out)))
        else $error("stalled result lost or changed");

endmodule
